/* design/sts_pkg.sv */
// Shared types and constants for the sorted table search unit.
// Used by sts_ctrl, sts_datapath and sorted_table_search_unit; depends on nothing.
package sts_pkg;

  // Field widths of the item words
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 7;
  localparam int KEY_W   = 32;
  localparam int POS_W   = 7;
  localparam int CNT_W   = 4;

  // Configuration port
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 3;
  localparam int CFG_IDX_W = CFG_AW - 2;
  localparam int ENTRY_W   = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = '0;
  localparam logic [ENTRY_W-1:0]   ENTRY_COUNT_RST = 8'd128;

  // Default table depth
  localparam int DEPTH_DEF = 128;

  // Item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SORT   = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT_START,
    ST_SORT_GETV,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_SRCH_INIT,
    ST_SRCH_CMP,
    ST_EMIT
  } state_t;

  // Table read address select
  typedef enum logic [1:0] {
    RD_I,
    RD_JM1,
    RD_MID
  } rd_sel_t;

  // Table write address/data select
  typedef enum logic [1:0] {
    WR_SLOT,
    WR_J_DATA,
    WR_J_V
  } wr_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    cap_item;
    logic    mem_we;
    wr_sel_t wr_sel;
    rd_sel_t rd_sel;
    logic    i_init;
    logic    i_inc;
    logic    j_load;
    logic    j_dec;
    logic    load_v;
    logic    srch_init;
    logic    srch_step;
    logic    cnt_inc;
    logic    found_set;
    logic    out_load;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic i_end;   // next outer sort index has reached the count
    logic j_zero;  // next insertion index is zero
    logic gt;      // read entry is greater than the held key
    logic live;    // next search interval is not empty
    logic eq;      // read entry equals the search key
  } dp_sts_t;

endpackage

/* design/sts_ctrl.sv */
// Controller state machine of the sorted table search unit.
// Sequences load, insertion sort and binary search; depends on sts_pkg.
module sts_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [sts_pkg::CMD_W-1:0] in_cmd,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  sts_pkg::dp_sts_t          sts,
  output sts_pkg::ctrl_cmd_t        cmd
);
  import sts_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.wr_sel = WR_SLOT;
    cmd.rd_sel = RD_I;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_item = 1'b1;
          case (cmd_t'(in_cmd))
            CMD_LOAD: begin
              cmd.mem_we = 1'b1;
              cmd.wr_sel = WR_SLOT;
              state_nxt  = ST_EMIT;
            end
            CMD_SORT:   state_nxt = ST_SORT_START;
            CMD_SEARCH: state_nxt = ST_SRCH_INIT;
            default:    state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_SORT_START: begin
        cmd.i_init = 1'b1;
        cmd.rd_sel = RD_I;
        state_nxt  = sts.i_end ? ST_EMIT : ST_SORT_GETV;
      end
      ST_SORT_GETV: begin
        cmd.load_v = 1'b1;
        cmd.j_load = 1'b1;
        cmd.rd_sel = RD_JM1;
        state_nxt  = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        cmd.mem_we = 1'b1;
        if (sts.gt) begin
          // shift the larger entry up one place
          cmd.wr_sel = WR_J_DATA;
          cmd.j_dec  = 1'b1;
          cmd.rd_sel = RD_JM1;
          state_nxt  = sts.j_zero ? ST_SORT_PUT : ST_SORT_CMP;
        end else begin
          // drop the held key into its hole, move to the next entry
          cmd.wr_sel = WR_J_V;
          cmd.i_inc  = 1'b1;
          cmd.rd_sel = RD_I;
          state_nxt  = sts.i_end ? ST_EMIT : ST_SORT_GETV;
        end
      end
      ST_SORT_PUT: begin
        cmd.mem_we = 1'b1;
        cmd.wr_sel = WR_J_V;
        cmd.i_inc  = 1'b1;
        cmd.rd_sel = RD_I;
        state_nxt  = sts.i_end ? ST_EMIT : ST_SORT_GETV;
      end
      ST_SRCH_INIT: begin
        cmd.srch_init = 1'b1;
        cmd.rd_sel    = RD_MID;
        state_nxt     = sts.live ? ST_SRCH_CMP : ST_EMIT;
      end
      ST_SRCH_CMP: begin
        cmd.cnt_inc = 1'b1;
        if (sts.eq) begin
          cmd.found_set = 1'b1;
          state_nxt     = ST_EMIT;
        end else begin
          cmd.srch_step = 1'b1;
          cmd.rd_sel    = RD_MID;
          state_nxt     = sts.live ? ST_SRCH_CMP : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output word valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  // Result word is never loaded over one that has not been taken
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending word");

  // Every accepted word moves the controller out of idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("accepted word did not start work");

  // Slot writes only happen at acceptance
  a_slot_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mem_we && cmd.wr_sel == WR_SLOT) |-> (state_r == ST_IDLE && in_valid))
    else $error("slot write outside acceptance");

  // A new result appears only after the emit state
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT))
    else $error("result valid raised outside emit");

endmodule

/* design/sts_datapath.sv */
// Datapath of the sorted table search unit: key table memory, sort and search
// index registers, comparators and the result register. Depends on sts_pkg.
module sts_datapath #(
  parameter int DEPTH = sts_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic [sts_pkg::ENTRY_W-1:0]       entry_count,
  input  logic [sts_pkg::SLOT_W-1:0]        in_slot,
  input  logic signed [sts_pkg::KEY_W-1:0]  in_key,
  input  sts_pkg::ctrl_cmd_t                cmd,
  output sts_pkg::dp_sts_t                  sts,
  output logic                              out_found,
  output logic [sts_pkg::POS_W-1:0]         out_position,
  output logic [sts_pkg::CNT_W-1:0]         out_compare_count
);
  import sts_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  // Key table
  logic signed [KEY_W-1:0] mem [DEPTH];
  logic signed [KEY_W-1:0] rd_data_r;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic signed [KEY_W-1:0] wr_data;
  logic                    wr_en;
  logic                    slot_ok;

  // Working registers
  logic [CW-1:0]           n_c;
  logic [CW-1:0]           i_r, i_nxt;
  logic [AW-1:0]           j_r, j_nxt;
  logic signed [KEY_W-1:0] v_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [SW-1:0]    l_r, l_nxt;
  logic signed [SW-1:0]    r_r, r_nxt;
  logic signed [SW-1:0]    mid_s;
  logic [SW:0]             sum_c;
  logic [AW-1:0]           mid_c;
  logic [AW-1:0]           mid_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    found_r;
  logic                    lt;

  // Active entry count, clipped to the table depth
  always_comb begin
    if (32'(entry_count) > 32'(DEPTH)) begin
      n_c = CW'(DEPTH);
    end else begin
      n_c = CW'(entry_count);
    end
  end

  assign lt = (key_r < rd_data_r);

  // Sort indices
  always_comb begin
    i_nxt = i_r;
    if (cmd.i_init) begin
      i_nxt = CW'(1);
    end else if (cmd.i_inc) begin
      i_nxt = i_r + CW'(1);
    end
    j_nxt = j_r;
    if (cmd.j_load) begin
      j_nxt = AW'(i_r);
    end else if (cmd.j_dec) begin
      j_nxt = j_r - AW'(1);
    end
  end

  // Search interval and next probe
  assign mid_s = SW'({1'b0, mid_r});

  always_comb begin
    l_nxt = l_r;
    r_nxt = r_r;
    if (cmd.srch_init) begin
      l_nxt = '0;
      r_nxt = SW'({1'b0, n_c}) - SW'(1);
    end else if (cmd.srch_step) begin
      if (lt) begin
        r_nxt = mid_s - SW'(1);
      end else begin
        l_nxt = mid_s + SW'(1);
      end
    end
  end

  assign sum_c = {l_nxt[SW-1], l_nxt} + {r_nxt[SW-1], r_nxt};
  assign mid_c = sum_c[AW:1];

  // Status to the controller
  assign sts.i_end  = (i_nxt >= n_c);
  assign sts.j_zero = (j_nxt == '0);
  assign sts.gt     = (rd_data_r > v_r);
  assign sts.live   = (r_nxt >= l_nxt);
  assign sts.eq     = (rd_data_r == key_r);

  // Table address and data selection
  assign slot_ok = (32'(in_slot) < 32'(DEPTH));

  always_comb begin
    case (cmd.rd_sel)
      RD_I:    rd_addr = AW'(i_nxt);
      RD_JM1:  rd_addr = j_nxt - AW'(1);
      RD_MID:  rd_addr = mid_c;
      default: rd_addr = mid_c;
    endcase
    case (cmd.wr_sel)
      WR_SLOT: begin
        wr_addr = AW'(in_slot);
        wr_data = in_key;
        wr_en   = cmd.mem_we && slot_ok;
      end
      WR_J_DATA: begin
        wr_addr = j_r;
        wr_data = rd_data_r;
        wr_en   = cmd.mem_we;
      end
      default: begin
        wr_addr = j_r;
        wr_data = v_r;
        wr_en   = cmd.mem_we;
      end
    endcase
  end

  // Table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Working registers
  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    l_r <= l_nxt;
    r_r <= r_nxt;
    if (cmd.load_v) begin
      v_r <= rd_data_r;
    end
    if (cmd.cap_item) begin
      key_r   <= in_key;
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.found_set) begin
        found_r <= 1'b1;
      end
    end
    if (cmd.srch_init || cmd.srch_step) begin
      mid_r <= mid_c;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found         <= found_r;
      out_position      <= found_r ? POS_W'(mid_r) : '0;
      out_compare_count <= cnt_r;
    end
  end

endmodule

/* design/sorted_table_search_unit.sv */
// Sorted table search unit, top level: APB-style register, controller and
// datapath. Depends on sts_pkg, sts_ctrl and sts_datapath.
//
// Usage: each input word carries cmd, slot and key. Load writes key at slot
// (slots at or past DEPTH are ignored), sort orders the first entry_count
// keys ascending with an insertion sort over the table memory, search runs a
// binary search over those entries. Every word gives one result word with
// found, position and compare_count (all zero for load, sort and unused cmd).
// From acceptance to result valid, one word at a time:
//   load / unused cmd : straight to the emit state
//   search            : init, then one compare state per probe (one memory
//                       read per probe), until a match or an empty interval
//   sort              : per outer entry a key read, then a compare and shift
//                       per entry moved, set by the single table read port
// The next word is accepted in the cycle after the result is loaded, even
// while that result is still waiting at out_valid; if the receiver stalls,
// the following result waits in the emit state until the word is taken.
// Reset clears the controller and sets entry_count to 128; the table keeps
// whatever it held and must be loaded before it is sorted or searched.
module sorted_table_search_unit #(
  parameter int DEPTH = sts_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sts_pkg::CMD_W-1:0]         in_cmd,
  input  logic [sts_pkg::SLOT_W-1:0]        in_slot,
  input  logic signed [sts_pkg::KEY_W-1:0]  in_key,
  // result words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_found,
  output logic [sts_pkg::POS_W-1:0]         out_position,
  output logic [sts_pkg::CNT_W-1:0]         out_compare_count,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sts_pkg::CFG_AW-1:0]        paddr,
  input  logic [sts_pkg::CFG_DW-1:0]        pwdata,
  output logic [sts_pkg::CFG_DW-1:0]        prdata,
  output logic                              pready
);
  import sts_pkg::*;

  logic [ENTRY_W-1:0]   entry_count_r;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  ctrl_cmd_t            cmd;
  dp_sts_t              sts;

  // Register file access
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= ENTRY_COUNT_RST;
    end else if (cfg_wr && reg_idx == REG_ENTRY_COUNT) begin
      entry_count_r <= pwdata[ENTRY_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_ENTRY_COUNT) begin
      prdata = CFG_DW'(entry_count_r);
    end
  end

  // Controller
  sts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  sts_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk               (clk),
    .entry_count       (entry_count_r),
    .in_slot           (in_slot),
    .in_key            (in_key),
    .cmd               (cmd),
    .sts               (sts),
    .out_found         (out_found),
    .out_position      (out_position),
    .out_compare_count (out_compare_count)
  );

endmodule
